// File: rtl/qrm_pkg.sv
// Shared constants and types for the quaternion to rotation matrix block.
// Used by qrm_div and quaternion_to_rotation_matrix; depends on nothing else.
package qrm_pkg;

    localparam int IN_W     = 16;           // input component width, Q4.12
    localparam int OUT_FRAC = 14;           // fraction bits of a matrix entry
    localparam int OUT_W    = OUT_FRAC + 2; // Q2.14
    localparam int PROD_W   = 2 * IN_W;     // one signed product
    localparam int SUM_W    = PROD_W + 1;   // squared length
    localparam int DIF_W    = PROD_W + 2;   // signed difference of two sums
    localparam int MAG_W    = PROD_W;       // magnitude of a numerator
    localparam int REM_W    = SUM_W;        // divider remainder, below the divisor
    localparam int TRY_W    = REM_W + 1;    // shifted remainder under test
    localparam int QUO_W    = OUT_FRAC + 3; // floor(mag * 2^(OUT_FRAC+2) / s)
    localparam int DIV_STG  = QUO_W;        // one quotient bit per stage
    localparam int NLANE    = 9;            // matrix entries
    localparam int NPROD    = 10;           // distinct component products
    localparam int NST      = DIV_STG + 3;  // product, sum, divider, output

    localparam logic [OUT_W-1:0]  ONE       = OUT_W'(1) << OUT_FRAC;
    localparam logic [NLANE-1:0]  DIAG_MASK = 9'b100_010_001;

    // Sign of each entry and the degenerate flag, carried beside the divider.
    typedef struct packed {
        logic [NLANE-1:0] neg;
        logic             degen;
    } t_side;

endpackage

// File: rtl/qrm_div.sv
// Nine-lane restoring divider pipeline, one quotient bit per register stage.
// Depends on qrm_pkg; stage loads are driven by the top level's flow control.
module qrm_div import qrm_pkg::*; (
    input  logic                 i_clk,
    input  logic [DIV_STG-1:0]   i_ld,
    input  logic [MAG_W-1:0]     i_mag [NLANE],
    input  logic [SUM_W-1:0]     i_den,
    input  t_side                i_side,
    output logic [QUO_W-1:0]     o_quo [NLANE],
    output t_side                o_side
);

    logic [REM_W-1:0] r_rem  [DIV_STG][NLANE];
    logic [QUO_W-1:0] r_quo  [DIV_STG][NLANE];
    logic [SUM_W-1:0] r_den  [DIV_STG];
    t_side            r_side [DIV_STG];

    for (genvar j = 0; j < DIV_STG; j++) begin : g_stg
        logic [REM_W-1:0] n_rem [NLANE];
        logic [QUO_W-1:0] n_quo [NLANE];
        logic [SUM_W-1:0] den_in;
        t_side            side_in;

        if (j == 0) begin : g_first
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_next
            assign den_in  = r_den[j-1];
            assign side_in = r_side[j-1];
        end

        for (genvar l = 0; l < NLANE; l++) begin : g_lane
            logic [TRY_W-1:0] t;
            logic [TRY_W-1:0] diff;
            logic [QUO_W-1:0] q_in;
            logic             q_bit;

            if (j == 0) begin : g_t0
                assign t    = TRY_W'(i_mag[l]);
                assign q_in = '0;
            end else begin : g_tn
                assign t    = {r_rem[j-1][l], 1'b0};
                assign q_in = r_quo[j-1][l];
            end

            // The test value stays below twice the divisor, so the sign of the
            // difference tells whether the quotient bit is set.
            assign diff      = t - {1'b0, den_in};
            assign q_bit     = ~diff[TRY_W-1];
            assign n_rem[l]  = q_bit ? diff[REM_W-1:0] : t[REM_W-1:0];
            assign n_quo[l]  = {q_in[QUO_W-2:0], q_bit};
        end

        always_ff @(posedge i_clk) begin
            if (i_ld[j]) begin
                r_rem[j]  <= n_rem;
                r_quo[j]  <= n_quo;
                r_den[j]  <= den_in;
                r_side[j] <= side_in;
            end
        end
    end

    assign o_quo  = r_quo[DIV_STG-1];
    assign o_side = r_side[DIV_STG-1];

endmodule

// File: rtl/quaternion_to_rotation_matrix.sv
// Quaternion to 3x3 rotation matrix, top level with flow control.
// Depends on qrm_pkg and qrm_div.
//
// Input channel: i_valid with the four Q4.12 components; a request is taken at
// a clock edge where i_valid is high and o_stall is low. Output channel:
// o_valid with nine Q2.14 entries and the degenerate flag; a request leaves at
// an edge where o_valid is high and i_stall is low.
// Configuration: i_cfg_valid / o_cfg_ready write degenerate_threshold (Q8.24).
// o_cfg_ready is always high; write only while no request is in flight.
// Twenty register stages: one product stage, one sum stage, seventeen divider
// stages (one quotient bit each) and the output register. A request passes
// through them in that order; o_valid rises when it reaches the output register.
// One request enters per cycle while o_stall is low; the rate is set by the pipeline.
// Each stage moves on when the stage after it is empty or moving, so while the
// receiver stalls, empty stages still fill and o_stall rises only once every
// stage holds a request. Nothing is dropped or repeated under stall.
// Synchronous reset empties the pipeline and clears the threshold to zero.
module quaternion_to_rotation_matrix import qrm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [IN_W-1:0]  i_quat_x,
    input  logic signed [IN_W-1:0]  i_quat_y,
    input  logic signed [IN_W-1:0]  i_quat_z,
    input  logic signed [IN_W-1:0]  i_quat_w,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [OUT_W-1:0] o_m00,
    output logic signed [OUT_W-1:0] o_m01,
    output logic signed [OUT_W-1:0] o_m02,
    output logic signed [OUT_W-1:0] o_m10,
    output logic signed [OUT_W-1:0] o_m11,
    output logic signed [OUT_W-1:0] o_m12,
    output logic signed [OUT_W-1:0] o_m20,
    output logic signed [OUT_W-1:0] o_m21,
    output logic signed [OUT_W-1:0] o_m22,
    output logic                    o_degenerate,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [31:0]             i_cfg_data
);

    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_WW = 3;
    localparam int P_XY = 4;
    localparam int P_ZW = 5;
    localparam int P_XZ = 6;
    localparam int P_YW = 7;
    localparam int P_YZ = 8;
    localparam int P_XW = 9;
    localparam int S_SUM = 1;

    logic [31:0]              r_thr;
    logic [NST-1:0]           r_v;
    logic [NST:0]             rdy;
    logic [NST-1:0]           vin;
    logic signed [PROD_W-1:0] r_prod [NPROD];
    logic signed [PROD_W-1:0] n_prod [NPROD];
    logic [MAG_W-1:0]         r_mag  [NLANE];
    logic [MAG_W-1:0]         n_mag  [NLANE];
    logic [SUM_W-1:0]         r_sum;
    logic [SUM_W-1:0]         n_sum;
    t_side                    r_side;
    t_side                    n_side;
    logic [QUO_W-1:0]         quo    [NLANE];
    t_side                    dv_side;
    logic [OUT_W-1:0]         r_m    [NLANE];
    logic [OUT_W-1:0]         n_m    [NLANE];
    logic                     r_degen;

    // Configuration register.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    // Per-stage flow control: a stage loads when it is empty or its
    // successor is loading.
    always_comb begin
        rdy[NST] = ~i_stall;
        for (int k = NST - 1; k >= 0; k--) begin
            rdy[k] = ~r_v[k] | rdy[k+1];
        end
        vin[0] = i_valid;
        for (int k = 1; k < NST; k++) begin
            vin[k] = r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= vin[k];
                end
            end
        end
    end

    assign o_stall = ~rdy[0];
    assign o_valid = r_v[NST-1];

    // Stage 0: the ten component products.
    always_comb begin
        n_prod[P_XX] = i_quat_x * i_quat_x;
        n_prod[P_YY] = i_quat_y * i_quat_y;
        n_prod[P_ZZ] = i_quat_z * i_quat_z;
        n_prod[P_WW] = i_quat_w * i_quat_w;
        n_prod[P_XY] = i_quat_x * i_quat_y;
        n_prod[P_ZW] = i_quat_z * i_quat_w;
        n_prod[P_XZ] = i_quat_x * i_quat_z;
        n_prod[P_YW] = i_quat_y * i_quat_w;
        n_prod[P_YZ] = i_quat_y * i_quat_z;
        n_prod[P_XW] = i_quat_x * i_quat_w;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && vin[0]) begin
            r_prod <= n_prod;
        end
    end

    // Stage 1: squared length, threshold test, numerator signs and magnitudes.
    always_comb begin
        logic signed [DIF_W-1:0] sq [4];
        logic signed [DIF_W-1:0] d  [NLANE];
        logic signed [DIF_W-1:0] pr [NPROD];

        for (int i = 0; i < NPROD; i++) begin
            pr[i] = DIF_W'(r_prod[i]);
        end
        for (int i = 0; i < 4; i++) begin
            sq[i] = pr[i];
        end

        d[0] = (sq[P_XX] + sq[P_WW]) - (sq[P_YY] + sq[P_ZZ]);
        d[1] = pr[P_XY] - pr[P_ZW];
        d[2] = pr[P_XZ] + pr[P_YW];
        d[3] = pr[P_XY] + pr[P_ZW];
        d[4] = (sq[P_YY] + sq[P_WW]) - (sq[P_XX] + sq[P_ZZ]);
        d[5] = pr[P_YZ] - pr[P_XW];
        d[6] = pr[P_XZ] - pr[P_YW];
        d[7] = pr[P_YZ] + pr[P_XW];
        d[8] = (sq[P_ZZ] + sq[P_WW]) - (sq[P_XX] + sq[P_YY]);

        for (int l = 0; l < NLANE; l++) begin
            n_side.neg[l] = d[l][DIF_W-1];
            n_mag[l]      = d[l][DIF_W-1] ? MAG_W'(-d[l]) : MAG_W'(d[l]);
        end

        n_sum        = SUM_W'((sq[P_XX] + sq[P_YY]) + (sq[P_ZZ] + sq[P_WW]));
        n_side.degen = n_sum <= SUM_W'(r_thr);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[S_SUM] && vin[S_SUM]) begin
            r_mag  <= n_mag;
            r_sum  <= n_sum;
            r_side <= n_side;
        end
    end

    // Stages 2 to NST-2: the divider. A degenerate request may carry a zero
    // divisor; its quotients are ignored at the output.
    qrm_div u_div (
        .i_clk  (i_clk),
        .i_ld   (rdy[NST-2:2] & vin[NST-2:2]),
        .i_mag  (r_mag),
        .i_den  (r_sum),
        .i_side (r_side),
        .o_quo  (quo),
        .o_side (dv_side)
    );

    // Last stage: round half away from zero, saturate, apply the sign.
    always_comb begin
        logic [QUO_W-1:0] v;
        logic [QUO_W:0]   rnd;
        logic [QUO_W-1:0] res;

        for (int l = 0; l < NLANE; l++) begin
            // Diagonal entries need one fewer fraction bit of the quotient.
            v   = DIAG_MASK[l] ? (quo[l] >> 1) : quo[l];
            rnd = {1'b0, v} + (QUO_W+1)'(1);
            res = rnd[QUO_W:1];
            if (res > QUO_W'(ONE)) begin
                res = QUO_W'(ONE);
            end
            if (dv_side.degen) begin
                n_m[l] = DIAG_MASK[l] ? ONE : '0;
            end else if (dv_side.neg[l]) begin
                n_m[l] = OUT_W'(-res);
            end else begin
                n_m[l] = OUT_W'(res);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[NST-1] && vin[NST-1]) begin
            r_m     <= n_m;
            r_degen <= dv_side.degen;
        end
    end

    assign o_m00        = r_m[0];
    assign o_m01        = r_m[1];
    assign o_m02        = r_m[2];
    assign o_m10        = r_m[3];
    assign o_m11        = r_m[4];
    assign o_m12        = r_m[5];
    assign o_m20        = r_m[6];
    assign o_m21        = r_m[7];
    assign o_m22        = r_m[8];
    assign o_degenerate = r_degen;

`ifndef ASSERT_OFF
    a_stall_from_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> i_stall)
        else $error("input stalled while the output side was not stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_degen_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_m00 == ONE && o_m11 == ONE && o_m22 == ONE
            && o_m01 == 0 && o_m12 == 0 && o_m20 == 0)
        else $error("degenerate request did not give the identity matrix");

    a_entry_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_m00 <= $signed(ONE) && o_m00 >= -$signed(ONE)
            && o_m01 <= $signed(ONE) && o_m01 >= -$signed(ONE))
        else $error("matrix entry outside plus or minus one");
`endif

endmodule

// File: tb/quaternion_to_rotation_matrix_tb.sv
// Self-checking testbench for quaternion_to_rotation_matrix.
// Depends on qrm_pkg and the RTL top level; holds its own bit-exact matrix predictor.
`timescale 1ns / 1ps

module quaternion_to_rotation_matrix_tb;
    import qrm_pkg::*;

    localparam int LATENCY = NST + 5;

    typedef struct {
        logic signed [IN_W-1:0] x, y, z, w;
    } t_quat;

    typedef struct {
        logic signed [OUT_W-1:0] m [NLANE];
        logic                    degen;
    } t_rot;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic i_stall = 0;
    logic signed [IN_W-1:0] i_quat_x = 0, i_quat_y = 0, i_quat_z = 0, i_quat_w = 0;
    logic i_cfg_valid = 0;
    logic [31:0] i_cfg_data = 0;
    logic o_stall, o_valid, o_degenerate, o_cfg_ready;
    logic signed [OUT_W-1:0] o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22;

    t_quat pending_quats [$];
    t_rot  expected_mats [$];
    logic [31:0] threshold = 0;
    int send_idle = 7, recv_idle = 68;
    bit hold_off = 0;
    int n_errors = 0, n_quats = 0, n_mats = 0, n_degen = 0;

    quaternion_to_rotation_matrix u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_quat_x(i_quat_x), .i_quat_y(i_quat_y), .i_quat_z(i_quat_z), .i_quat_w(i_quat_w),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_m00(o_m00), .o_m01(o_m01), .o_m02(o_m02),
        .o_m10(o_m10), .o_m11(o_m11), .o_m12(o_m12),
        .o_m20(o_m20), .o_m21(o_m21), .o_m22(o_m22),
        .o_degenerate(o_degenerate),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Rounded, saturated value of (a-b)*2^(OUT_FRAC+extra)/s, ties away from zero.
    function automatic logic [OUT_W-1:0] rot_entry(longint a, longint b, longint s, int extra);
        longint mag, q;
        bit neg;
        neg = a < b;
        mag = neg ? b - a : a - b;
        q = (((mag << (OUT_FRAC + extra + 1)) / s) + 1) >>> 1;
        if (q > (longint'(1) << OUT_FRAC)) q = longint'(1) << OUT_FRAC;
        return neg ? OUT_W'(-q) : OUT_W'(q);
    endfunction

    function automatic t_rot quat_to_rot(t_quat q, logic [31:0] thr);
        t_rot r;
        longint x, y, z, w, xx, yy, zz, ww, s;
        x = q.x; y = q.y; z = q.z; w = q.w;
        xx = x * x; yy = y * y; zz = z * z; ww = w * w;
        s = xx + yy + zz + ww;
        // The squared length always fits here, and the threshold scale matches Q8.24.
        if (s <= longint'(thr)) begin
            foreach (r.m[k]) r.m[k] = 0;
            r.m[0] = ONE; r.m[4] = ONE; r.m[8] = ONE;
            r.degen = 1;
            return r;
        end
        r.m[0] = rot_entry(xx + ww, yy + zz, s, 0);
        r.m[1] = rot_entry(x * y, z * w, s, 1);
        r.m[2] = rot_entry(x * z, -(y * w), s, 1);
        r.m[3] = rot_entry(x * y, -(z * w), s, 1);
        r.m[4] = rot_entry(yy + ww, xx + zz, s, 0);
        r.m[5] = rot_entry(y * z, x * w, s, 1);
        r.m[6] = rot_entry(x * z, y * w, s, 1);
        r.m[7] = rot_entry(y * z, -(x * w), s, 1);
        r.m[8] = rot_entry(zz + ww, xx + yy, s, 0);
        r.degen = 0;
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
        n_errors++;
    endtask

    // Driver: a new request is presented only once the previous one has gone.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                expected_mats.push_back(quat_to_rot('{i_quat_x, i_quat_y, i_quat_z, i_quat_w},
                                                    threshold));
                n_quats++;
            end
            if (pending_quats.size() > 0 && !hold_off && $urandom_range(99) >= send_idle) begin
                t_quat q;
                q = pending_quats.pop_front();
                i_quat_x <= q.x; i_quat_y <= q.y; i_quat_z <= q.z; i_quat_w <= q.w;
                i_valid <= 1;
            end else begin
                i_valid <= 0;
            end
        end
    end

    // Monitor: compare each accepted matrix with the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_mats.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    t_rot want;
                    logic signed [OUT_W-1:0] got [NLANE];
                    want = expected_mats.pop_front();
                    got = '{o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22};
                    foreach (got[k])
                        if (got[k] !== want.m[k])
                            report_mismatch($sformatf("m%0d%0d", k / 3, k % 3), got[k], want.m[k]);
                    if (o_degenerate !== want.degen)
                        report_mismatch("degenerate", o_degenerate, want.degen);
                    n_mats++;
                    if (want.degen) n_degen++;
                end
            end
            i_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    task automatic wait_drained();
        while (pending_quats.size() > 0 || i_valid || expected_mats.size() > 0)
            @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    task automatic write_threshold(logic [31:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        threshold = v;
        i_cfg_valid <= 0;
        @(negedge i_clk);
    endtask

    function automatic logic [IN_W-1:0] rand_comp(int mode);
        case (mode)
            0: return IN_W'($urandom);
            1: return IN_W'($urandom_range(8) - 4);
            2: return IN_W'(int'($urandom_range(8192)) - 4096);
            3: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return IN_W'(int'($urandom_range(600)) - 300);
        endcase
    endfunction

    task automatic queue_random(int n);
        repeat (n) begin
            int mode;
            mode = $urandom_range(5);
            pending_quats.push_back('{rand_comp(mode), rand_comp(mode),
                                      rand_comp(mode), rand_comp(mode)});
        end
    endtask

    initial begin
        logic [31:0] thr_list [6];
        int idle_s [6], idle_r [6];
        thr_list = '{32'd0, 32'hffff_ffff, 32'h0100_0000, $urandom, 32'h0010_0000,
                     $urandom_range(32'h0002_0000)};
        idle_s = '{7, 7, 68, 68, 0, 0};
        idle_r = '{68, 68, 7, 7, 0, 0};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        for (int p = 0; p < 6; p++) begin
            write_threshold(thr_list[p]);
            send_idle = idle_s[p];
            recv_idle = idle_r[p];
            if (p == 0 || p == 4) begin
                // Zero, identity, axes, extreme magnitudes and mixed signs.
                pending_quats.push_back('{0, 0, 0, 0});
                pending_quats.push_back('{0, 0, 0, 4096});
                pending_quats.push_back('{0, 0, 0, -4096});
                pending_quats.push_back('{4096, 0, 0, 0});
                pending_quats.push_back('{0, 4096, 0, 0});
                pending_quats.push_back('{0, 0, 4096, 0});
                pending_quats.push_back('{1, 0, 0, 0});
                pending_quats.push_back('{1, 1, 1, 1});
                pending_quats.push_back('{-1, -1, -1, -1});
                pending_quats.push_back('{-32768, -32768, -32768, -32768});
                pending_quats.push_back('{32767, 32767, 32767, 32767});
                pending_quats.push_back('{-32768, 32767, -32768, 32767});
                pending_quats.push_back('{2048, 2048, 2048, 2048});
                pending_quats.push_back('{-32768, 0, 0, 0});
                pending_quats.push_back('{0, 0, 0, 32767});
                pending_quats.push_back('{2896, 0, 0, 2896});
                pending_quats.push_back('{0, 0, 3, 4});
            end
            queue_random(150);
            if (p == 5) begin
                // Hold the sender until the pipeline has emptied out completely.
                repeat (40) @(negedge i_clk);
                hold_off = 1;
                while (expected_mats.size() > 0 || i_valid) @(negedge i_clk);
                hold_off = 0;
            end
            queue_random(150);
            wait_drained();
        end

        $display("Covered %0d quaternions over six threshold and flow-control settings,",
                 n_quats);
        $display("%0d matrices checked, %0d of them degenerate.", n_mats, n_degen);
        if (n_errors == 0 && expected_mats.size() == 0) begin
            $display("quaternion_to_rotation_matrix_tb: PASS");
        end else begin
            $display("quaternion_to_rotation_matrix_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Timed out with %0d results outstanding.", expected_mats.size());
        $display("quaternion_to_rotation_matrix_tb: FAIL");
        $finish;
    end

endmodule
